// ===== rtl/core/tus_pkg.sv =====
// shared types and constants for the thresholded 3x3 unsharp-mask sharpener
package tus_pkg;

    localparam int PIX_W         = 8;
    localparam int CFG_DATA_W    = 11;
    localparam int CFG_IDX_W     = 1;
    localparam int MAX_ROW_WIDTH_DEF = 1024;
    localparam int ROW_WIDTH_RST = 640;
    localparam int MIN_ROW_WIDTH = 3;
    localparam int THRESH_RST    = 15;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [3:0]       t_blur;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 1'b1;

endpackage

// ===== rtl/core/tus_kernel.sv =====
// threshold test and sharpening of the window centre against the blur
module tus_kernel
    import tus_pkg::*;
(
    input  t_pix  i_centre,
    input  t_blur i_blur,
    input  t_pix  i_threshold,
    output t_pix  o_pixel
);

    t_pix blur_ext;
    t_pix diff;
    t_pix abs_diff;
    logic sharpen;

    always_comb begin
        blur_ext = {4'd0, i_blur};
        diff     = i_centre - blur_ext;
        abs_diff = (i_centre > blur_ext) ? diff : (blur_ext - i_centre);
        sharpen  = abs_diff > i_threshold;
        // add a quarter of the wrapped difference, wrap to 8 bits
        o_pixel  = sharpen ? (i_centre + {2'd0, diff[7:2]}) : i_centre;
    end

endmodule

// ===== rtl/core/threshold_unsharp_3x3.sv =====
// top level of the thresholded 3x3 unsharp-mask sharpener with line memory
//
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_ready     i_pixel_in, i_frame_start
//  output    out        o_out_valid / i_out_ready   o_pixel_out, o_row_end
//  config    in         i_cfg_we (no wait)          i_cfg_idx, i_cfg_data
//
//  one beat in per clock sustained while the output is not stalled; a result passes
//  through the memory read, the blur sum, and the threshold and output register
//  the line memory is a single 16-bit wide port pair whose read is registered on accept;
//  a write-back to the address just read is forwarded
//  reset (synchronous, active low) clears counters, window and pipe valids;
//  the line memory is not cleared
//  a stalled output backs up through the pipe; beats are taken while any stage is free
module threshold_unsharp_3x3
    import tus_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PIX_W-1:0]      i_pixel_in,
    input  logic                  i_frame_start,
    // output stream
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic                  o_row_end,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // column address width and effective width range
    localparam int CW   = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
    localparam int WW   = $clog2(MAX_ROW_WIDTH + 1);
    localparam int CMPW = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
    localparam int EFF_RST = (ROW_WIDTH_RST > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH
                                                             : ROW_WIDTH_RST;
    localparam int MEM_W = 2 * PIX_W;
    localparam logic [1:0] ROW_FULL = 2'd2;

    // ---------------- configuration ----------------
    logic [WW-1:0]  r_eff_w;       // clamped row width
    t_pix           r_threshold;
    logic [CMPW-1:0] cfg_raw;
    logic [WW-1:0]  cfg_eff_w;

    always_comb begin
        cfg_raw = CMPW'(i_cfg_data);
        if (cfg_raw < CMPW'(MIN_ROW_WIDTH)) begin
            cfg_eff_w = WW'(MIN_ROW_WIDTH);
        end else if (cfg_raw > CMPW'(MAX_ROW_WIDTH)) begin
            cfg_eff_w = WW'(MAX_ROW_WIDTH);
        end else begin
            cfg_eff_w = cfg_raw[WW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w     <= WW'(EFF_RST);
            r_threshold <= t_pix'(THRESH_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROW_WIDTH:      r_eff_w     <= cfg_eff_w;
                CFG_EDGE_THRESHOLD: r_threshold <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipe control ----------------
    logic r_s1_valid, r_s2_valid, r_out_valid;
    logic out_en, s2_en, s1_en, acc, s1_move;

    assign out_en  = !r_out_valid || i_out_ready;
    assign s2_en   = !r_s2_valid || out_en;
    assign s1_en   = !r_s1_valid || s2_en;
    assign acc     = i_in_valid && s1_en;
    assign s1_move = r_s1_valid && s2_en;   // also the memory write-back
    assign o_in_ready = s1_en;

    // ---------------- raster position ----------------
    logic [CW-1:0] r_col;
    logic [1:0]    r_row;          // row count saturating at two
    logic [CW-1:0] a_col;
    logic [1:0]    a_row;
    logic [WW-1:0] col_inc;
    logic          a_prod;
    logic          a_rend;

    always_comb begin
        if (i_frame_start) begin
            a_col = '0;
            a_row = '0;
        end else if (WW'(r_col) >= r_eff_w) begin
            // width lowered mid-row: start a fresh row
            a_col = '0;
            a_row = (r_row == ROW_FULL) ? ROW_FULL : r_row + 2'd1;
        end else begin
            a_col = r_col;
            a_row = r_row;
        end
        col_inc = WW'(a_col) + WW'(1);
        a_prod  = (a_row == ROW_FULL) && (a_col >= CW'(2));
        a_rend  = WW'(a_col) == (r_eff_w - WW'(1));
    end

    logic [CW-1:0] n_col;
    logic [1:0]    n_row;

    always_comb begin
        if (col_inc >= r_eff_w) begin
            n_col = '0;
            n_row = (a_row == ROW_FULL) ? ROW_FULL : a_row + 2'd1;
        end else begin
            n_col = col_inc[CW-1:0];
            n_row = a_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- line memory ----------------
    // each word holds {row before previous, previous row} for one column
    logic [MEM_W-1:0] r_line_mem [MAX_ROW_WIDTH];
    logic [MEM_W-1:0] r_rd_data;
    logic [MEM_W-1:0] r_fwd_data;
    logic             r_fwd;

    logic [CW-1:0]    r_s1_col;
    t_pix             r_s1_pix;
    logic             r_s1_prod;
    logic             r_s1_rend;

    t_pix top, mid;
    logic [MEM_W-1:0] wr_data;
    logic [MEM_W-1:0] rd_word;

    assign rd_word = r_fwd ? r_fwd_data : r_rd_data;
    assign top     = rd_word[MEM_W-1:PIX_W];
    assign mid     = rd_word[PIX_W-1:0];
    assign wr_data = {mid, r_s1_pix};

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_line_mem[r_s1_col] <= wr_data;
        end
        if (acc) begin
            r_rd_data  <= r_line_mem[a_col];
            r_fwd_data <= wr_data;
        end
    end

    // forward when the beat reads the column being written back this edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (acc) begin
            r_fwd <= s1_move && (a_col == r_s1_col);
        end
    end

    // ---------------- stage 1: window and blur sum ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_en) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_col  <= a_col;
            r_s1_pix  <= i_pixel_in;
            r_s1_prod <= a_prod;
            r_s1_rend <= a_rend;
        end
    end

    // [0..2] column c-2 top/mid/bottom, [3..5] column c-1
    t_pix r_win [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_move) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top;
            r_win[4] <= mid;
            r_win[5] <= r_s1_pix;
        end
    end

    // weighted sum, every term and the total wrapped to 8 bits
    t_pix sum8;

    always_comb begin
        sum8 = r_win[0] + r_win[2] + top + r_s1_pix
             + {r_win[1][6:0], 1'b0} + {r_win[3][6:0], 1'b0}
             + {r_win[5][6:0], 1'b0} + {mid[6:0], 1'b0}
             + {r_win[4][5:0], 2'b00};
    end

    // ---------------- stage 2: blur and centre ----------------
    t_blur r_s2_blur;
    t_pix  r_s2_centre;
    logic  r_s2_rend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_en) begin
            r_s2_valid <= r_s1_valid && r_s1_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_blur   <= sum8[7:4];
            r_s2_centre <= r_win[4];
            r_s2_rend   <= r_s1_rend;
        end
    end

    // ---------------- output register ----------------
    t_pix sharp_pix;
    t_pix r_out_pix;
    logic r_out_rend;

    tus_kernel u_kernel (
        .i_centre    (r_s2_centre),
        .i_blur      (r_s2_blur),
        .i_threshold (r_threshold),
        .o_pixel     (sharp_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_s2_valid) begin
            r_out_pix  <= sharp_pix;
            r_out_rend <= r_s2_rend;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_out_pix;
    assign o_row_end   = r_out_rend;

`ifndef NO_ASSERTIONS
    // a result is only produced for a full window
    a_prod_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_prod) |-> (r_s1_col >= CW'(2)))
        else $error("result flagged for a border column");

    // row count saturates at two
    a_row_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row != 2'd3)
        else $error("row count passed saturation");

    // read of the column written back this edge must be forwarded
    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && s1_move && (a_col == r_s1_col)) |=> r_fwd)
        else $error("missed line memory forward");

    // a full pipe behind a stalled output takes no beat
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && r_s2_valid && r_s1_valid) |-> !o_in_ready)
        else $error("beat accepted into a full pipe");
`endif

endmodule
